// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the byte pipe RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define MCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers reset cycles
`define MCBP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mcbp_pkg.sv =====
// ---------------------------------------------------------------------------
// mcbp_pkg
// Sizes, codes and word types of the multi-channel byte pipe.
// ---------------------------------------------------------------------------
package mcbp_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int BUF_DEPTH    = 256;
  localparam int MAX_READ     = 64;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W  = $clog2(BUF_DEPTH);
  localparam int FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_READ + 1);
  localparam int ADDR_W = $clog2(NUM_CHANNELS * BUF_DEPTH);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLOSE = 2'd3;

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_BAD   = 3'd1;
  localparam logic [2:0] STAT_FULL  = 3'd2;
  localparam logic [2:0] STAT_EMPTY = 3'd3;
  localparam logic [2:0] STAT_TABLE = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] channel;
    logic [7:0] wr_byte;
    logic [6:0] read_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] rd_byte;
    logic       byte_valid;
    logic       last;
    logic [2:0] given_channel;
    logic       wake;
    logic [8:0] fill_level;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic more;
  } sts_t;

endpackage

// ===== rtl/mcbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// mcbp_ctrl
// Command sequencer: accept, execute, then stream read bytes.
// ---------------------------------------------------------------------------
module mcbp_ctrl import mcbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    ctl.load  = start && !busy_r;
    ctl.exec  = (state_r == ST_EXEC);
    ctl.step  = (state_r == ST_READ);
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.load) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts.more ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        if (!sts.more) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== rtl/mcbp_dpath.sv =====
// ---------------------------------------------------------------------------
// mcbp_dpath
// Channel table, shared byte store and result register.
// ---------------------------------------------------------------------------
module mcbp_dpath import mcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  in_word_t  in_word,
  output sts_t      sts,
  output logic      out_valid,
  output out_word_t out_word
);

  in_word_t          cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  rd_idx_r [NUM_CHANNELS];
  logic [IDX_W-1:0]  rd_idx_nxt [NUM_CHANNELS];
  logic [IDX_W-1:0]  wr_idx_r [NUM_CHANNELS];
  logic [IDX_W-1:0]  wr_idx_nxt [NUM_CHANNELS];
  logic [FILL_W-1:0] fill_r [NUM_CHANNELS];
  logic [FILL_W-1:0] fill_nxt [NUM_CHANNELS];
  logic              open_r [NUM_CHANNELS];
  logic              open_nxt [NUM_CHANNELS];
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic              res_vld_r, res_vld_nxt;
  out_word_t         res_r, res_nxt;

  logic [7:0]        mem [NUM_CHANNELS * BUF_DEPTH];
  logic [7:0]        mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;

  logic [CH_W-1:0]   cur_ch;
  logic              chan_ok;
  logic [FILL_W-1:0] cur_fill;
  logic [IDX_W-1:0]  cur_rd, cur_wr;
  logic              cur_open;
  logic [LEN_W-1:0]  len_sat, len_eff;
  logic              free_found;
  logic [CH_W-1:0]   free_ch;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(BUF_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [CH_W-1:0] ch,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(ch) * ADDR_W'(BUF_DEPTH) + ADDR_W'(idx);
  endfunction

  assign cur_ch   = ctl.step ? ch_r : cmd_r.channel[CH_W-1:0];
  assign chan_ok  = (32'(cmd_r.channel) < NUM_CHANNELS);
  assign cur_fill = fill_r[cur_ch];
  assign cur_rd   = rd_idx_r[cur_ch];
  assign cur_wr   = wr_idx_r[cur_ch];
  assign cur_open = open_r[cur_ch];

  assign len_sat = (32'(cmd_r.read_length) > MAX_READ) ? LEN_W'(MAX_READ)
                                                       : LEN_W'(cmd_r.read_length);
  assign len_eff = (32'(cur_fill) < 32'(len_sat)) ? LEN_W'(cur_fill) : len_sat;

  // lowest closed channel
  always_comb begin
    free_found = 1'b0;
    free_ch    = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_found = 1'b1;
        free_ch    = CH_W'(i);
      end
    end
  end

  always_comb begin
    cmd_nxt     = ctl.load ? in_word : cmd_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    fill_nxt    = fill_r;
    open_nxt    = open_r;
    remain_nxt  = remain_r;
    ch_nxt      = ch_r;
    res_vld_nxt = 1'b0;
    res_nxt     = '0;
    res_nxt.last = 1'b1;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = store_addr(cur_ch, cur_rd);
    sts.more    = 1'b0;

    if (ctl.exec) begin
      res_vld_nxt = 1'b1;
      if (cmd_r.command == CMD_ALLOC) begin
        if (free_found) begin
          rd_idx_nxt[free_ch] = '0;
          wr_idx_nxt[free_ch] = '0;
          fill_nxt[free_ch]   = '0;
          open_nxt[free_ch]   = 1'b1;
          res_nxt.status        = STAT_OK;
          res_nxt.given_channel = 3'(free_ch);
        end else begin
          res_nxt.status = STAT_TABLE;
        end
      end else if (!(chan_ok && cur_open)) begin
        res_nxt.status = STAT_BAD;
      end else begin
        unique case (cmd_r.command)
          CMD_WRITE: begin
            if (cur_fill == FILL_W'(BUF_DEPTH)) begin
              res_nxt.status     = STAT_FULL;
              res_nxt.fill_level = 9'(cur_fill);
            end else begin
              mem_we              = 1'b1;
              mem_addr            = store_addr(cur_ch, cur_wr);
              wr_idx_nxt[cur_ch]  = idx_inc(cur_wr);
              fill_nxt[cur_ch]    = cur_fill + FILL_W'(1);
              res_nxt.status      = STAT_OK;
              res_nxt.wake        = 1'b1;
              res_nxt.fill_level  = 9'(cur_fill + FILL_W'(1));
            end
          end
          CMD_CLOSE: begin
            open_nxt[cur_ch]   = 1'b0;
            res_nxt.status     = STAT_OK;
            res_nxt.wake       = 1'b1;
            res_nxt.fill_level = 9'(cur_fill);
          end
          CMD_READ: begin
            if (cur_fill == '0) begin
              res_nxt.status = STAT_EMPTY;
            end else if (len_sat == '0) begin
              res_nxt.status     = STAT_OK;
              res_nxt.fill_level = 9'(cur_fill);
            end else begin
              // first byte goes out now, the rest stream from the read state
              mem_re             = 1'b1;
              rd_idx_nxt[cur_ch] = idx_inc(cur_rd);
              fill_nxt[cur_ch]   = cur_fill - FILL_W'(1);
              remain_nxt         = len_eff - LEN_W'(1);
              ch_nxt             = cur_ch;
              sts.more           = (len_eff > LEN_W'(1));
              res_nxt.status     = STAT_OK;
              res_nxt.byte_valid = 1'b1;
              res_nxt.last       = (len_eff == LEN_W'(1));
              res_nxt.fill_level = 9'(cur_fill - FILL_W'(1));
            end
          end
          default: res_nxt.status = STAT_BAD;
        endcase
      end
    end else if (ctl.step) begin
      mem_re             = 1'b1;
      rd_idx_nxt[cur_ch] = idx_inc(cur_rd);
      fill_nxt[cur_ch]   = cur_fill - FILL_W'(1);
      remain_nxt         = remain_r - LEN_W'(1);
      sts.more           = (remain_r > LEN_W'(1));
      res_vld_nxt        = 1'b1;
      res_nxt.status     = STAT_OK;
      res_nxt.byte_valid = 1'b1;
      res_nxt.last       = (remain_r == LEN_W'(1));
      res_nxt.fill_level = 9'(cur_fill - FILL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rd_idx_r[i] <= '0;
        wr_idx_r[i] <= '0;
        fill_r[i]   <= '0;
        open_r[i]   <= 1'b0;
      end
    end else begin
      res_vld_r <= res_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
      wr_idx_r  <= wr_idx_nxt;
      fill_r    <= fill_nxt;
      open_r    <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    remain_r <= remain_nxt;
    ch_r     <= ch_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= cmd_r.wr_byte;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  // merge the store read data into the result word
  always_comb begin
    out_word         = res_r;
    out_word.rd_byte = res_r.byte_valid ? mem_q_r : 8'd0;
  end

  assign out_valid = res_vld_r;

endmodule

// ===== rtl/multi_channel_byte_pipe.sv =====
// ---------------------------------------------------------------------------
// multi_channel_byte_pipe
// A command is registered when start is taken while not busy and runs in the execute
// state; its result is registered before out_valid. Allocate, write, close and error
// give one result each; a read streams one byte a cycle from the store read port.
// Results cannot be stalled; each is valid for one cycle on out_valid.
// Synchronous active-low reset closes all channels and clears their indices.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_byte_pipe import mcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  ctl_t ctl;
  sts_t sts;

  mcbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  mcbp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_word   (in_word),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  `MCBP_ASSERT(a_first_result, (start && !busy) |-> ##2 out_valid, "no result for command")
  `MCBP_ASSERT(a_gap_after_last, (out_valid && out_word.last) |=> !out_valid, "result after last")
  `MCBP_ASSERT(a_stream_busy, (out_valid && !out_word.last) |-> busy, "idle mid read stream")
  `MCBP_ASSERT_RST(a_reset_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule
